// File: hw/rtl/porter_duff_pixel_compositor_core_macros.svh
// Assertion macros for the Porter-Duff pixel compositor core.
`ifndef PORTER_DUFF_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define PORTER_DUFF_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PDC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDC_ASSERT(lbl, clk, rst, prop, msg)
`define PDC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/pdc_pkg.sv
// Shared types, operator codes and weight helpers for the compositor.
package pdc_pkg;

  localparam int LANES = 4;
  localparam int CH_W = 8;
  localparam int PROD_W = 2 * CH_W;
  localparam int ALPHA_LANE = 3;

  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_SOURCE    = 4'd1;
  localparam logic [3:0] OP_DEST      = 4'd2;
  localparam logic [3:0] OP_OVER      = 4'd3;
  localparam logic [3:0] OP_DEST_OVER = 4'd4;
  localparam logic [3:0] OP_IN        = 4'd5;
  localparam logic [3:0] OP_DEST_IN   = 4'd6;
  localparam logic [3:0] OP_OUT       = 4'd7;
  localparam logic [3:0] OP_DEST_OUT  = 4'd8;
  localparam logic [3:0] OP_ATOP      = 4'd9;
  localparam logic [3:0] OP_DEST_ATOP = 4'd10;
  localparam logic [3:0] OP_XOR       = 4'd11;
  localparam logic [3:0] OP_PLUS      = 4'd12;

  localparam logic [3:0] OP_MODE_RESET = OP_OVER;

  localparam logic REG_OP_MODE      = 1'b0;
  localparam logic REG_BG_HAS_ALPHA = 1'b1;

  localparam logic [1:0] W_ZERO  = 2'd0;
  localparam logic [1:0] W_FULL  = 2'd1;
  localparam logic [1:0] W_ALPHA = 2'd2;
  localparam logic [1:0] W_INV   = 2'd3;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  typedef struct packed {
    logic [CH_W-1:0] fa;
    logic [CH_W-1:0] fb;
  } weights_t;

  typedef struct packed {
    logic [1:0] sel_a;
    logic [1:0] sel_b;
  } op_sel_t;

  function automatic op_sel_t op_select(input logic [3:0] op);
    op_sel_t s;
    case (op)
      OP_SOURCE:    s = '{sel_a: W_FULL,  sel_b: W_ZERO};
      OP_DEST:      s = '{sel_a: W_ZERO,  sel_b: W_FULL};
      OP_OVER:      s = '{sel_a: W_FULL,  sel_b: W_INV};
      OP_DEST_OVER: s = '{sel_a: W_INV,   sel_b: W_FULL};
      OP_IN:        s = '{sel_a: W_ALPHA, sel_b: W_ZERO};
      OP_DEST_IN:   s = '{sel_a: W_ZERO,  sel_b: W_ALPHA};
      OP_OUT:       s = '{sel_a: W_INV,   sel_b: W_ZERO};
      OP_DEST_OUT:  s = '{sel_a: W_ZERO,  sel_b: W_INV};
      OP_ATOP:      s = '{sel_a: W_ALPHA, sel_b: W_INV};
      OP_DEST_ATOP: s = '{sel_a: W_INV,   sel_b: W_ALPHA};
      OP_XOR:       s = '{sel_a: W_INV,   sel_b: W_INV};
      OP_PLUS:      s = '{sel_a: W_FULL,  sel_b: W_FULL};
      default:      s = '{sel_a: W_ZERO,  sel_b: W_ZERO};
    endcase
    return s;
  endfunction

  function automatic logic [CH_W-1:0] weight_of(input logic [1:0] sel,
                                                input logic [CH_W-1:0] alpha);
    logic [CH_W-1:0] w;
    case (sel)
      W_FULL:  w = CH_MAX;
      W_ALPHA: w = alpha;
      W_INV:   w = CH_MAX - alpha;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/pdc_weight.sv
// Operator decode: turns the operator and the two alphas into the blend weights.
module pdc_weight
  import pdc_pkg::*;
(
  input  logic [3:0]      op_mode,
  input  logic [CH_W-1:0] ad,
  input  logic [CH_W-1:0] as,
  output weights_t        w
);

  op_sel_t sel;

  assign sel  = op_select(op_mode);
  assign w.fa = weight_of(sel.sel_a, ad);
  assign w.fb = weight_of(sel.sel_b, as);

endmodule

// File: hw/rtl/pdc_lane.sv
// One channel lane: two weighted products, rounding divide by 255, saturating add.
module pdc_lane
  import pdc_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [CH_W-1:0] c_ov,
  input  logic [CH_W-1:0] c_bg,
  input  weights_t        w,
  output logic [CH_W-1:0] result
);

  logic [PROD_W-1:0]   prod_a;
  logic [PROD_W-1:0]   prod_b;
  logic [PROD_W-1:0]   ya;
  logic [PROD_W-1:0]   yb;
  logic [PROD_W+8:0]   ma;
  logic [PROD_W+8:0]   mb;
  logic [CH_W:0]       sum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= c_ov * w.fa;
      prod_b <= c_bg * w.fb;
    end
  end

  // floor((p + 128) / 255) equals ((p + 129) * 257) >> 16 for every 8x8 product.
  assign ya  = prod_a + PROD_W'(129);
  assign yb  = prod_b + PROD_W'(129);
  assign ma  = {9'd0, ya} + {1'b0, ya, 8'd0};
  assign mb  = {9'd0, yb} + {1'b0, yb, 8'd0};
  assign sum = {1'b0, ma[PROD_W+7:PROD_W]} + {1'b0, mb[PROD_W+7:PROD_W]};

  assign result = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];

endmodule

// File: hw/rtl/porter_duff_pixel_compositor_core.sv
// Top level of the Porter-Duff pixel compositor: stream ports, registers, lanes.
// The core composites one premultiplied RGBA overlay pixel over one background
// pixel per clock with the operator held in op_mode, and keeps taking an item
// every cycle as long as the output side is ready. An item passes three register
// stages: the operator decode, loaded at the accepting edge, the four channel
// multipliers, and the output register after the divide-by-255 and saturating
// add. While a result waits on the output, the whole pipeline and the input
// hold. The four lanes run side by side, one per channel. When bg_has_alpha is 0
// the background alpha is taken as opaque and the output alpha reads 0.
// Configure only while no item is in flight.
`include "porter_duff_pixel_compositor_core_macros.svh"
module porter_duff_pixel_compositor_core
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ov_red, ov_green, ov_blue, ov_alpha, bg_red, bg_green, bg_blue, bg_alpha
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]      op_mode;
  logic            bg_has_alpha;
  logic            adv;
  logic            v1;
  logic            v2;
  logic            last1;
  logic            last2;
  logic [CH_W-1:0] s1_ov [LANES];
  logic [CH_W-1:0] s1_bg [LANES];
  weights_t        s1_w;
  weights_t        w_in;
  logic [CH_W-1:0] ad_in;
  logic [CH_W-1:0] lane_out [LANES];
  logic [CH_W-1:0] alpha_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode      <= OP_MODE_RESET;
      bg_has_alpha <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_OP_MODE:      op_mode <= pwdata[3:0];
        REG_BG_HAS_ALPHA: bg_has_alpha <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OP_MODE:      prdata = {28'd0, op_mode};
      REG_BG_HAS_ALPHA: prdata = {31'd0, bg_has_alpha};
      default:          prdata = '0;
    endcase
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign ad_in         = bg_has_alpha ? s_axis_tdata[63:56] : CH_MAX;

  pdc_weight u_weight (
    .op_mode (op_mode),
    .ad      (ad_in),
    .as      (s_axis_tdata[31:24]),
    .w       (w_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      m_axis_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        s1_ov[i] <= s_axis_tdata[i*CH_W +: CH_W];
        s1_bg[i] <= (i == ALPHA_LANE) ? ad_in : s_axis_tdata[(LANES+i)*CH_W +: CH_W];
      end
      s1_w  <= w_in;
      last1 <= s_axis_tlast;
      last2 <= last1;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pdc_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .c_ov   (s1_ov[g]),
      .c_bg   (s1_bg[g]),
      .w      (s1_w),
      .result (lane_out[g])
    );
  end

  assign alpha_out = bg_has_alpha ? lane_out[ALPHA_LANE] : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {alpha_out, lane_out[2], lane_out[1], lane_out[0]};
      m_axis_tlast <= last2;
    end
  end

  `PDC_ASSERT_NR(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")
  `PDC_ASSERT(a_accept_fill, clk, rst, (s_axis_tvalid && s_axis_tready) |=> v1, "item lost")
  `PDC_ASSERT(a_drain, clk, rst, (v2 && s_axis_tready) |=> m_axis_tvalid, "result stalled")

endmodule

// File: sim/porter_duff_pixel_compositor_core_tb.sv
// Self-checking testbench for the Porter-Duff pixel compositor core.
`timescale 1ns / 1ps
module porter_duff_pixel_compositor_core_tb
  import pdc_pkg::*;
();

  localparam logic [3:0] OP_UNKNOWN = 4'd15;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PIPE_DEPTH = 3;
  localparam int unsigned RANDOM_PHASES = 26;
  localparam int unsigned ITEMS_PER_PHASE = 25;

  typedef struct packed {
    logic [7:0] bg_alpha;
    logic [7:0] bg_blue;
    logic [7:0] bg_green;
    logic [7:0] bg_red;
    logic [7:0] ov_alpha;
    logic [7:0] ov_blue;
    logic [7:0] ov_green;
    logic [7:0] ov_red;
  } pixel_pair_t;

  typedef struct packed {
    logic       row_end;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } composite_t;

  class compositor_scoreboard;
    logic [3:0] op_mode;
    logic bg_has_alpha;
    composite_t pending_pixels[$];
    int unsigned pairs_in;
    int unsigned results_out;
    int unsigned mismatches;

    function new();
      op_mode = OP_MODE_RESET;
      bg_has_alpha = 1'b1;
    endfunction

    function void operator_weights(output logic [1:0] ov_sel, output logic [1:0] bg_sel);
      case (op_mode)
        OP_SOURCE:    {ov_sel, bg_sel} = {W_FULL, W_ZERO};
        OP_DEST:      {ov_sel, bg_sel} = {W_ZERO, W_FULL};
        OP_OVER:      {ov_sel, bg_sel} = {W_FULL, W_INV};
        OP_DEST_OVER: {ov_sel, bg_sel} = {W_INV, W_FULL};
        OP_IN:        {ov_sel, bg_sel} = {W_ALPHA, W_ZERO};
        OP_DEST_IN:   {ov_sel, bg_sel} = {W_ZERO, W_ALPHA};
        OP_OUT:       {ov_sel, bg_sel} = {W_INV, W_ZERO};
        OP_DEST_OUT:  {ov_sel, bg_sel} = {W_ZERO, W_INV};
        OP_ATOP:      {ov_sel, bg_sel} = {W_ALPHA, W_INV};
        OP_DEST_ATOP: {ov_sel, bg_sel} = {W_INV, W_ALPHA};
        OP_XOR:       {ov_sel, bg_sel} = {W_INV, W_INV};
        OP_PLUS:      {ov_sel, bg_sel} = {W_FULL, W_FULL};
        default:      {ov_sel, bg_sel} = {W_ZERO, W_ZERO};
      endcase
    endfunction

    function int unsigned weight_for(logic [1:0] sel, int unsigned alpha);
      case (sel)
        W_FULL:  return 255;
        W_ALPHA: return alpha;
        W_INV:   return 255 - alpha;
        default: return 0;
      endcase
    endfunction

    function logic [7:0] blend_channel(int unsigned c_ov, int unsigned fa,
                                       int unsigned c_bg, int unsigned fb);
      int unsigned sum;
      sum = (c_ov * fa + 128) / 255 + (c_bg * fb + 128) / 255;
      return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function composite_t composite_pixel(pixel_pair_t px, logic row_end);
      composite_t r;
      logic [1:0] ov_sel;
      logic [1:0] bg_sel;
      int unsigned ad;
      int unsigned fa;
      int unsigned fb;
      ad = bg_has_alpha ? int'(px.bg_alpha) : 255;
      operator_weights(ov_sel, bg_sel);
      fa = weight_for(ov_sel, ad);
      fb = weight_for(bg_sel, int'(px.ov_alpha));
      r.red = blend_channel(int'(px.ov_red), fa, int'(px.bg_red), fb);
      r.green = blend_channel(int'(px.ov_green), fa, int'(px.bg_green), fb);
      r.blue = blend_channel(int'(px.ov_blue), fa, int'(px.bg_blue), fb);
      r.alpha = bg_has_alpha ? blend_channel(int'(px.ov_alpha), fa, ad, fb) : 8'd0;
      r.row_end = row_end;
      return r;
    endfunction

    function void note_pixel(pixel_pair_t px, logic row_end);
      pending_pixels.push_back(composite_pixel(px, row_end));
      pairs_in++;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: result %0d: %s", $time, results_out, msg);
      mismatches++;
    endtask

    task check_result(composite_t got);
      composite_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h", got));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("out_red %h, want %h", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("out_green %h, want %h", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("out_blue %h, want %h", got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report_mismatch($sformatf("out_alpha %h, want %h", got.alpha, want.alpha));
        if (got.row_end !== want.row_end)
          report_mismatch($sformatf("row_end_out %b, want %b", got.row_end, want.row_end));
      end
      results_out++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // ov_red, ov_green, ov_blue, ov_alpha, bg_red, bg_green, bg_blue, bg_alpha
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_red, out_green, out_blue, out_alpha
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  compositor_scoreboard board = new();
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned settings_used = 0;

  porter_duff_pixel_compositor_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result({m_axis_tlast, m_axis_tdata});
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] op, input logic has_alpha);
    while (board.pending_pixels.size() != 0) @(posedge clk);
    write_reg(REG_OP_MODE, 32'(op));
    write_reg(REG_BG_HAS_ALPHA, 32'(has_alpha));
    board.op_mode = op;
    board.bg_has_alpha = has_alpha;
    settings_used++;
  endtask

  task automatic send_pixel(input pixel_pair_t px, input logic row_end);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tlast <= row_end;
    do @(posedge clk); while (!s_axis_tready);
    board.note_pixel(px, row_end);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    int unsigned a;
    p = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        // Well-formed premultiplied pixels: no color channel exceeds its alpha.
        a = ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
        p.ov_alpha = 8'(a);
        p.ov_red = 8'($urandom_range(a));
        p.ov_green = 8'($urandom_range(a));
        p.ov_blue = 8'($urandom_range(a));
        a = ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
        p.bg_alpha = 8'(a);
        p.bg_red = 8'($urandom_range(a));
        p.bg_green = 8'($urandom_range(a));
        p.bg_blue = 8'($urandom_range(a));
      end
      5: begin
        for (int i = 0; i < 8; i++) p[i*8 +: 8] = {8{$urandom_range(1) == 1}};
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic run_directed();
    logic [3:0] ops[$];
    ops = '{OP_CLEAR, OP_SOURCE, OP_DEST, OP_OVER, OP_DEST_OVER, OP_IN, OP_DEST_IN,
            OP_OUT, OP_DEST_OUT, OP_ATOP, OP_DEST_ATOP, OP_XOR, OP_PLUS, OP_UNKNOWN};
    // Reset settings first, with all-zero and all-one pixels.
    send_pixel('0, 1'b0);
    send_pixel('1, 1'b1);
    foreach (ops[i]) begin
      s_axis_tvalid <= 1'b0;
      configure(ops[i], 1'b1);
      send_pixel(64'hFA_F0_A0_5A_B4_32_64_C8, i[0]);
    end
    s_axis_tvalid <= 1'b0;
    configure(OP_PLUS, 1'b0);
    send_pixel('1, 1'b1);
    send_pixel(64'h00_40_80_C0_7F_3C_20_10, 1'b0);
    s_axis_tvalid <= 1'b0;
    configure(OP_ATOP, 1'b0);
    send_pixel(64'h12_E0_70_30_90_80_40_20, 1'b1);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [3:0] op;
    logic has_alpha;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      op = (p <= OP_PLUS) ? p[3:0] : 4'($urandom_range(OP_PLUS));
      has_alpha = (p <= OP_PLUS) ? p[0] : ($urandom_range(3) != 0);
      configure(op, has_alpha);
      case (p % 4)
        0: begin src_idle_pct = 0; sink_stall_pct = 0; end
        1: begin src_idle_pct = 60; sink_stall_pct = 0; end
        2: begin src_idle_pct = 0; sink_stall_pct = 60; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_pixel(random_pair(), $urandom_range(7) == 0);
      end
      s_axis_tvalid <= 1'b0;
    end
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    $display("Composited %0d pixel pairs into %0d results over %0d register settings,",
             board.pairs_in, board.results_out, settings_used);
    $display("covering all operators, both background alpha modes and four flow mixes.");
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found.", board.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_weight.sv
hw/rtl/pdc_lane.sv
hw/rtl/porter_duff_pixel_compositor_core.sv
sim/porter_duff_pixel_compositor_core_tb.sv
